>>> rtl/core/fdmc_pkg.sv
// Package for the fail-safe drive mode controller.
// Holds item codes, state and result structs and counter sizing.
// No dependencies.
package fdmc_pkg;

    localparam int COUNT_WIDTH  = 32;
    localparam int NUM_COUNTERS = 10;

    typedef logic [COUNT_WIDTH-1:0]  count_t;
    typedef logic [NUM_COUNTERS-1:0] bump_t;

    localparam logic [1:0] MODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_REMOTE = 2'd1;
    localparam logic [1:0] MODE_SAFE   = 2'd2;

    localparam logic [3:0] ACT_PEER_UP    = 4'd0;
    localparam logic [3:0] ACT_PEER_DOWN  = 4'd1;
    localparam logic [3:0] ACT_NET_DOWN   = 4'd2;
    localparam logic [3:0] ACT_NET_UP     = 4'd3;
    localparam logic [3:0] ACT_HB_LOST    = 4'd4;
    localparam logic [3:0] ACT_TELEMETRY  = 4'd5;
    localparam logic [3:0] ACT_LINK_ERR   = 4'd6;
    localparam logic [3:0] ACT_COMMAND    = 4'd7;
    localparam logic [3:0] ACT_READ_COUNT = 4'd8;

    localparam logic [2:0] CMD_TAKEOVER = 3'd0;
    localparam logic [2:0] CMD_FORWARD  = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_ESTOP    = 3'd3;
    localparam logic [2:0] CMD_RECOVER  = 3'd4;

    localparam int CNT_PEER_UP   = 0;
    localparam int CNT_PEER_DOWN = 1;
    localparam int CNT_NET_DOWN  = 2;
    localparam int CNT_NET_UP    = 3;
    localparam int CNT_HB_LOST   = 4;
    localparam int CNT_TELEMETRY = 5;
    localparam int CNT_LINK_ERR  = 6;
    localparam int CNT_EMERGENCY = 7;
    localparam int CNT_CONTROL   = 8;
    localparam int CNT_ACKS      = 9;

    localparam logic [7:0] FORWARD_SPEED_RESET = 8'd60;

    typedef struct packed {
        logic [3:0] action;
        logic [2:0] command;
        logic       ctrl;
        logic [3:0] counter_index;
    } item_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       emergency;
        logic       link;
        logic [7:0] speed;
        logic       gear;
        logic [1:0] last_mode;
        logic       log_nonempty;
    } drive_state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        emergency;
        logic        link;
        logic [7:0]  speed;
        logic        gear;
        logic        accepted;
        logic        logged;
        logic [31:0] counter_value;
    } result_t;

endpackage

>>> rtl/core/fdmc_counters.sv
// Bank of saturating event counters with one read port.
// Depends on fdmc_pkg.
module fdmc_counters
    import fdmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        bump_en,
    input  bump_t       bump,
    input  logic [3:0]  rd_index,
    output logic [31:0] rd_value
);

    count_t      cnt_reg [NUM_COUNTERS];
    logic [63:0] rd_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (bump_en)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                if (bump[i] && (cnt_reg[i] != '1))
                begin
                    cnt_reg[i] <= cnt_reg[i] + count_t'(1);
                end
            end
        end
    end

    always_comb
    begin
        rd_wide = '0;
        if (32'(rd_index) < NUM_COUNTERS)
        begin
            rd_wide = 64'(cnt_reg[rd_index]);
        end
        rd_value = (rd_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rd_wide[31:0];
    end

endmodule

>>> rtl/core/fdmc_update.sv
// Next-state and result logic for one item.
// Depends on fdmc_pkg.
module fdmc_update
    import fdmc_pkg::*;
(
    input  item_t        item,
    input  drive_state_t cur,
    input  logic [7:0]   forward_speed,
    input  logic [31:0]  rd_value,
    output drive_state_t nxt,
    output result_t      res,
    output bump_t        bump
);

    drive_state_t st;
    logic         log_req;
    logic         logged;
    logic         accepted;
    logic [31:0]  cval;

    always_comb
    begin
        st       = cur;
        log_req  = 1'b0;
        logged   = 1'b0;
        accepted = 1'b0;
        cval     = '0;
        bump     = '0;

        unique case (item.action)
            ACT_PEER_UP:
            begin
                st.link  = 1'b1;
                st.mode  = cur.emergency ? MODE_SAFE : MODE_AUTO;
                st.speed = '0;
                if (cur.emergency)
                begin
                    st.gear = 1'b0;
                end
                log_req = 1'b1;
                bump[CNT_PEER_UP] = 1'b1;
            end
            ACT_PEER_DOWN:
            begin
                st.link  = 1'b0;
                st.speed = '0;
                st.gear  = 1'b0;
                st.mode  = cur.emergency ? MODE_SAFE : MODE_AUTO;
                log_req  = 1'b1;
                bump[CNT_PEER_DOWN] = 1'b1;
            end
            ACT_NET_DOWN:
            begin
                st.link      = 1'b0;
                st.mode      = MODE_SAFE;
                st.emergency = 1'b1;
                st.speed     = '0;
                st.gear      = 1'b0;
                log_req      = 1'b1;
                bump[CNT_NET_DOWN]  = 1'b1;
                bump[CNT_EMERGENCY] = 1'b1;
            end
            ACT_NET_UP:
            begin
                st.link  = 1'b1;
                st.mode  = cur.emergency ? MODE_SAFE : MODE_AUTO;
                st.speed = '0;
                log_req  = 1'b1;
                bump[CNT_NET_UP] = 1'b1;
            end
            ACT_HB_LOST:
            begin
                st.mode      = MODE_SAFE;
                st.emergency = 1'b1;
                st.speed     = '0;
                st.gear      = 1'b0;
                log_req      = 1'b1;
                bump[CNT_HB_LOST]   = 1'b1;
                bump[CNT_EMERGENCY] = 1'b1;
            end
            ACT_TELEMETRY:
            begin
                bump[CNT_TELEMETRY] = 1'b1;
            end
            ACT_LINK_ERR:
            begin
                st.mode      = MODE_SAFE;
                st.emergency = 1'b1;
                st.speed     = '0;
                st.gear      = 1'b0;
                log_req      = 1'b1;
                bump[CNT_LINK_ERR]  = 1'b1;
                bump[CNT_EMERGENCY] = 1'b1;
            end
            ACT_COMMAND:
            begin
                bump[CNT_CONTROL]   = item.ctrl;
                bump[CNT_EMERGENCY] = (item.command == CMD_ESTOP);
                accepted = 1'b1;
                priority if (item.command == CMD_TAKEOVER && cur.mode == MODE_AUTO)
                begin
                    st.mode = MODE_REMOTE;
                    st.gear = 1'b1;
                    log_req = 1'b1;
                end
                else if (item.command == CMD_FORWARD && cur.mode == MODE_REMOTE
                         && !cur.emergency)
                begin
                    st.speed = forward_speed;
                end
                else if (item.command == CMD_STOP && cur.mode == MODE_REMOTE)
                begin
                    st.speed = '0;
                end
                else if (item.command == CMD_ESTOP)
                begin
                    st.mode      = MODE_SAFE;
                    st.emergency = 1'b1;
                    st.speed     = '0;
                    st.gear      = 1'b0;
                    log_req      = 1'b1;
                end
                else if (item.command == CMD_RECOVER && cur.mode == MODE_SAFE)
                begin
                    st.mode      = MODE_AUTO;
                    st.emergency = 1'b0;
                    st.speed     = '0;
                    st.gear      = 1'b0;
                    log_req      = 1'b1;
                end
                else
                begin
                    accepted = 1'b0;
                end
                bump[CNT_ACKS] = accepted;
            end
            ACT_READ_COUNT:
            begin
                cval = rd_value;
            end
            default:
            begin
            end
        endcase

        if (log_req && (!st.log_nonempty || st.last_mode != st.mode))
        begin
            st.last_mode    = st.mode;
            st.log_nonempty = 1'b1;
            logged          = 1'b1;
        end
    end

    assign nxt = st;
    assign res = {st.mode, st.emergency, st.link, st.speed, st.gear, accepted, logged, cval};

endmodule

>>> rtl/core/failsafe_drive_mode_controller_top.sv
// Top level of the fail-safe drive mode controller.
// Depends on fdmc_pkg, fdmc_counters and fdmc_update.
//
// An item accepted at a clock edge shows up as a result item right after the
// next edge, provided the output is free. The item is held in an input register,
// the mode, latch, speed, gear and counter updates are worked out from that
// register, and the result lands in an output register. One item per cycle
// is sustained while out_stall is low; state and counters update as the item
// enters the output register, which closes the loop between items. A stalled
// result holds while one more item waits in the input register. Write
// forward_speed only while no item is in flight; cfg_ready is always high.
module failsafe_drive_mode_controller_top
    import fdmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  action,
    input  logic [2:0]  command,
    input  logic        from_control_channel,
    input  logic [3:0]  counter_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  drive_mode,
    output logic        emergency_active,
    output logic        peer_linked,
    output logic [7:0]  speed_tenths,
    output logic        gear_engaged,
    output logic        command_accepted,
    output logic        mode_logged,
    output logic [31:0] counter_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic         s1_valid_reg;
    item_t        item_reg;
    drive_state_t state_reg;
    drive_state_t state_next;
    logic [7:0]   fwd_speed_reg;
    logic         out_valid_reg;
    result_t      result_reg;
    result_t      result_next;
    bump_t        bump;
    logic [31:0]  rd_value;
    logic         s1_adv;
    logic         in_accept;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    fdmc_counters u_counters (
        .clk      (clk),
        .rst_n    (rst_n),
        .bump_en  (s1_adv),
        .bump     (bump),
        .rd_index (item_reg.counter_index),
        .rd_value (rd_value)
    );

    fdmc_update u_update (
        .item          (item_reg),
        .cur           (state_reg),
        .forward_speed (fwd_speed_reg),
        .rd_value      (rd_value),
        .nxt           (state_next),
        .res           (result_next),
        .bump          (bump)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            fwd_speed_reg <= FORWARD_SPEED_RESET;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                fwd_speed_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.action        <= action;
            item_reg.command       <= command;
            item_reg.ctrl          <= from_control_channel;
            item_reg.counter_index <= counter_index;
        end
        if (s1_adv)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign drive_mode       = result_reg.mode;
    assign emergency_active = result_reg.emergency;
    assign peer_linked      = result_reg.link;
    assign speed_tenths     = result_reg.speed;
    assign gear_engaged     = result_reg.gear;
    assign command_accepted = result_reg.accepted;
    assign mode_logged      = result_reg.logged;
    assign counter_value    = result_reg.counter_value;

endmodule

>>> rtl/core/fdmc_checker.sv
// Port-level checker for the fail-safe drive mode controller, with its bind.
// Depends on fdmc_pkg and failsafe_drive_mode_controller_top.
module fdmc_checker
    import fdmc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  drive_mode,
    input logic        emergency_active,
    input logic [7:0]  speed_tenths,
    input logic        command_accepted,
    input logic [31:0] counter_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(counter_value)
        && $stable(drive_mode))
        else $error("stalled result item changed");

    a_latch_safe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && emergency_active |-> drive_mode == MODE_SAFE)
        else $error("emergency latch set outside safe stop");

    a_speed_remote: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && speed_tenths != 8'd0 |-> drive_mode == MODE_REMOTE
        && !emergency_active)
        else $error("nonzero speed outside remote control");

    a_ack_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_accepted |-> counter_value == 32'd0)
        else $error("acknowledged item carries a counter value");

endmodule

bind failsafe_drive_mode_controller_top fdmc_checker u_fdmc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .drive_mode       (drive_mode),
    .emergency_active (emergency_active),
    .speed_tenths     (speed_tenths),
    .command_accepted (command_accepted),
    .counter_value    (counter_value)
);
